@@ sv/rtrgf_pkg.sv @@
// ----------------------------------------------------------------------------
// rtrgf_pkg: shared constants and helpers for the recurrence converter
// Field widths, store geometry and the effective-order function used by the
// top level and the testbench.
// ----------------------------------------------------------------------------
package rtrgf_pkg;

    // Largest recurrence order held in the stores.
    localparam int MAX_ORDER = 64;

    // Store address width, and the width that can hold MAX_ORDER itself.
    localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CNT_W = $clog2(MAX_ORDER + 1);

    // Field widths.
    localparam int ORDER_W   = 7;
    localparam int TERM_W    = 32;
    localparam int DENOM_W   = TERM_W + 1;
    localparam int P_W       = 64;
    localparam int OUT_IDX_W = 6;

    // Width used when comparing the item count against the order.
    localparam int CMP_W = (ORDER_W > CNT_W) ? ORDER_W : CNT_W;

    // Order zero counts as one; orders above the store depth saturate.
    function automatic logic [CMP_W-1:0] eff_order(input logic [ORDER_W-1:0] order);
        logic [CMP_W-1:0] k;
        k = CMP_W'(order);
        if (k == CMP_W'(0)) begin
            k = CMP_W'(1);
        end else if (k > CMP_W'(MAX_ORDER)) begin
            k = CMP_W'(MAX_ORDER);
        end
        return k;
    endfunction

    // Keep the low six bits of a store index for the result fields.
    function automatic logic [OUT_IDX_W-1:0] idx_out(input logic [IDX_W-1:0] idx);
        logic [IDX_W+OUT_IDX_W-1:0] wide;
        wide = {{OUT_IDX_W{1'b0}}, idx};
        return wide[OUT_IDX_W-1:0];
    endfunction

endpackage

@@ sv/recurrence_to_rational_gf.sv @@
// ----------------------------------------------------------------------------
// recurrence_to_rational_gf: linear recurrence to rational generating function
// Stores each initial term and negated coefficient, and for every item emits
// one numerator coefficient by a truncated convolution over the stored terms.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                 Payload
//  -------  ---------  ------------------------  -------------------------------
//  cfg      in         i_cfg_valid/o_cfg_ready   i_cfg_order
//  in       in         i_in_valid/o_in_ready     i_initial_term, i_recurrence_coeff
//  out      out        o_out_valid/i_out_ready   numerator, denominator, index, flags
//
// Item i of a job, for i above zero, runs from its acceptance to the next
// acceptance in this order: one multiply-accumulate issue per earlier entry
// through the read ports of the two store memories, the registered read and
// the registered multiply, a drain, the write-back and the idle state that
// takes the next item. Item 0 goes from acceptance straight to write-back.
// Reset clears the control state only; the stores need no clearing, as an item
// reads only entries written earlier in the same job.
// A new item is taken while the previous result still waits at the output; a
// finished item holds in its final state until the output register is free.
//
module recurrence_to_rational_gf (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [rtrgf_pkg::ORDER_W-1:0]         i_cfg_order,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [rtrgf_pkg::TERM_W-1:0]   i_initial_term,
    input  logic signed [rtrgf_pkg::TERM_W-1:0]   i_recurrence_coeff,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [rtrgf_pkg::P_W-1:0]      o_numerator_coeff,
    output logic signed [rtrgf_pkg::DENOM_W-1:0]  o_denominator_coeff,
    output logic [rtrgf_pkg::OUT_IDX_W-1:0]       o_coeff_index,
    output logic                                  o_is_last,
    output logic [rtrgf_pkg::OUT_IDX_W-1:0]       o_numerator_degree,
    output logic                                  o_numerator_all_zero
);

    import rtrgf_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAC  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [ORDER_W-1:0] r_order;
    logic [IDX_W-1:0]   r_i, n_i;
    logic [IDX_W-1:0]   r_k, n_k;
    logic               r_issue, n_issue;
    logic               r_rd_v;
    logic               r_mul_v;
    logic [TERM_W-1:0]  r_a;
    logic [DENOM_W-1:0] r_q;
    logic [P_W-1:0]     r_acc, n_acc;
    logic [P_W-1:0]     r_prod;
    logic [OUT_IDX_W-1:0] r_top, n_top;
    logic               r_seen, n_seen;

    logic [P_W-1:0]       r_out_p;
    logic [DENOM_W-1:0]   r_out_q;
    logic [OUT_IDX_W-1:0] r_out_idx;
    logic                 r_out_last;
    logic [OUT_IDX_W-1:0] r_out_deg;
    logic                 r_out_zero;
    logic                 r_out_valid, n_out_valid;

    logic               in_acc;
    logic               load_out;
    logic               last;
    logic               p_nz;
    logic [IDX_W-1:0]   term_raddr;
    logic [TERM_W-1:0]  term_rdata;
    logic [DENOM_W-1:0] denom_rdata;
    logic signed [TERM_W+DENOM_W-1:0] prod_full;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign load_out    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Store memories: entry i holds a_i and q_{i+1}.
    assign term_raddr = r_i - IDX_W'(1) - r_k;

    rtrgf_ram #(.WIDTH(TERM_W), .DEPTH(MAX_ORDER)) u_term_ram (
        .i_clk   (i_clk),
        .i_we    (load_out),
        .i_waddr (r_i),
        .i_wdata (r_a),
        .i_raddr (term_raddr),
        .o_rdata (term_rdata)
    );

    rtrgf_ram #(.WIDTH(DENOM_W), .DEPTH(MAX_ORDER)) u_denom_ram (
        .i_clk   (i_clk),
        .i_we    (load_out),
        .i_waddr (r_i),
        .i_wdata (r_q),
        .i_raddr (r_k),
        .o_rdata (denom_rdata)
    );

    // Product of a stored term and a stored denominator coefficient.
    assign prod_full = $signed(term_rdata) * $signed(denom_rdata);

    // End of job and numerator tracking.
    assign last = (CMP_W'(r_i) + CMP_W'(1)) >= eff_order(r_order);
    assign p_nz = (r_acc != '0);

    // Sequencer and accumulator next state.
    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_k         = r_k;
        n_issue     = r_issue;
        n_acc       = r_acc;
        n_top       = r_top;
        n_seen      = r_seen;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_acc = {{(P_W-TERM_W){i_initial_term[TERM_W-1]}}, i_initial_term};
                    n_k   = '0;
                    if (r_i == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_issue = 1'b1;
                        n_state = S_MAC;
                    end
                end
            end
            S_MAC: begin
                if (r_issue) begin
                    if (r_k == r_i - IDX_W'(1)) begin
                        n_issue = 1'b0;
                    end else begin
                        n_k = r_k + IDX_W'(1);
                    end
                end
                if (r_mul_v) begin
                    n_acc = r_acc + r_prod;
                end
                if (!r_issue && !r_rd_v && !r_mul_v) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (last) begin
                        n_i    = '0;
                        n_top  = '0;
                        n_seen = 1'b0;
                    end else begin
                        n_i = r_i + IDX_W'(1);
                        if (p_nz) begin
                            n_top  = idx_out(r_i);
                            n_seen = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_order     <= ORDER_W'(1);
            r_i         <= '0;
            r_k         <= '0;
            r_issue     <= 1'b0;
            r_rd_v      <= 1'b0;
            r_mul_v     <= 1'b0;
            r_top       <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_k         <= n_k;
            r_issue     <= n_issue;
            r_rd_v      <= r_issue;
            r_mul_v     <= r_rd_v;
            r_top       <= n_top;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_order <= i_cfg_order;
            end
        end
    end

    // Payload registers: item operands, accumulator, product and result.
    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_prod <= prod_full[P_W-1:0];
        if (in_acc) begin
            r_a <= i_initial_term;
            r_q <= DENOM_W'(0) - {i_recurrence_coeff[TERM_W-1], i_recurrence_coeff};
        end
        if (load_out) begin
            r_out_p    <= r_acc;
            r_out_q    <= r_q;
            r_out_idx  <= idx_out(r_i);
            r_out_last <= last;
            r_out_deg  <= p_nz ? idx_out(r_i) : (r_seen ? r_top : '0);
            r_out_zero <= !(p_nz || r_seen);
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_numerator_coeff    = r_out_p;
    assign o_denominator_coeff  = r_out_q;
    assign o_coeff_index        = r_out_idx;
    assign o_is_last            = r_out_last;
    assign o_numerator_degree   = r_out_deg;
    assign o_numerator_all_zero = r_out_zero;

endmodule

@@ sv/rtrgf_ram.sv @@
// ----------------------------------------------------------------------------
// rtrgf_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
module rtrgf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for recurrence_to_rational_gf
// Feeds recurrence terms and coefficients through the valid/ready channels,
// with random idling on both sides and long output stalls. A behavioural
// predictor builds each expected result item. Every received result item is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import rtrgf_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 80;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_TARGET = 1050;   // random phases stop near this count
    localparam int TAIL_ITEMS    = 150;

    localparam logic [TERM_W-1:0]  TERM_MIN  = {1'b1, {(TERM_W-1){1'b0}}};
    localparam logic [TERM_W-1:0]  TERM_MAX  = {1'b0, {(TERM_W-1){1'b1}}};
    localparam logic [ORDER_W-1:0] ORDER_TOP = '1;

    // Kinds of value content used for random jobs.
    typedef enum int {
        FLAVOUR_WIDE,
        FLAVOUR_EDGES,
        FLAVOUR_SMALL,
        FLAVOUR_SPARSE
    } t_value_flavour;

    // One predicted result item.
    typedef struct packed {
        logic [P_W-1:0]       numer;
        logic [DENOM_W-1:0]   denom;
        logic [OUT_IDX_W-1:0] index;
        logic                 last;
        logic [OUT_IDX_W-1:0] degree;
        logic                 all_zero;
    } t_gf_coeff;

    // Clock, reset and block ports.
    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [ORDER_W-1:0]   cfg_order    = '0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic [TERM_W-1:0]    in_term      = '0;
    logic [TERM_W-1:0]    in_coeff     = '0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic [P_W-1:0]       out_numer;
    logic [DENOM_W-1:0]   out_denom;
    logic [OUT_IDX_W-1:0] out_index;
    logic                 out_last;
    logic [OUT_IDX_W-1:0] out_degree;
    logic                 out_all_zero;

    // Predictor state: order register, stored terms and negated coefficients.
    logic [ORDER_W-1:0]   gf_order     = ORDER_W'(1);
    longint               gf_terms [MAX_ORDER];
    longint               gf_denoms [MAX_ORDER];
    int                   gf_count     = 0;
    logic [OUT_IDX_W-1:0] gf_top       = '0;
    logic                 gf_seen      = 1'b0;

    t_gf_coeff            pending_coeffs [$];

    // Run control and statistics.
    bit                   idling         = 1'b1;
    int                   hold_request   = 0;
    int                   cycle_count    = 0;
    int                   mismatch_count = 0;
    int                   coeffs_checked = 0;
    int                   items_sent     = 0;
    int                   jobs_done      = 0;
    int                   orders_written = 0;

    recurrence_to_rational_gf dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_cfg_order          (cfg_order),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_initial_term       (in_term),
        .i_recurrence_coeff   (in_coeff),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_numerator_coeff    (out_numer),
        .o_denominator_coeff  (out_denom),
        .o_coeff_index        (out_index),
        .o_is_last            (out_last),
        .o_numerator_degree   (out_degree),
        .o_numerator_all_zero (out_all_zero)
    );

    always #5 clk = ~clk;

    // Abandon the run if it never completes.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results outstanding.",
                     cycle_count, pending_coeffs.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Predict the result item for one accepted item and advance the job state.
    function automatic t_gf_coeff predict_coeff(input logic [TERM_W-1:0] term,
                                                input logic [TERM_W-1:0] coeff);
        t_gf_coeff res;
        int        span;
        int        pos;
        int        j;
        longint    acc;
        longint    negated;
        span = int'(gf_order);
        if (span == 0) begin
            span = 1;
        end else if (span > MAX_ORDER) begin
            span = MAX_ORDER;
        end
        pos     = (gf_count >= MAX_ORDER) ? MAX_ORDER - 1 : gf_count;
        negated = -longint'($signed(coeff));
        // Truncated convolution of stored terms with the denominator, wrapping.
        acc = longint'($signed(term));
        for (j = 1; j <= pos; j++) begin
            acc += gf_terms[pos - j] * gf_denoms[j - 1];
        end
        gf_terms[pos]  = longint'($signed(term));
        gf_denoms[pos] = negated;
        if (acc != 0) begin
            gf_top  = pos[OUT_IDX_W-1:0];
            gf_seen = 1'b1;
        end
        res.numer    = acc;
        res.denom    = negated[DENOM_W-1:0];
        res.index    = pos[OUT_IDX_W-1:0];
        res.last     = (pos + 1 >= span);
        res.degree   = gf_seen ? gf_top : '0;
        res.all_zero = !gf_seen;
        // The job restarts after its last item.
        if (res.last) begin
            gf_count = 0;
            gf_top   = '0;
            gf_seen  = 1'b0;
            jobs_done++;
        end else begin
            gf_count = pos + 1;
        end
        return res;
    endfunction

    // Draw one term or coefficient of the given kind.
    function automatic logic [TERM_W-1:0] draw_value(input t_value_flavour flavour,
                                                     input bit is_coeff);
        int small_value;
        small_value = int'($urandom_range(0, 8)) - 4;
        case (flavour)
            FLAVOUR_EDGES: begin
                case ($urandom_range(0, 4))
                    0: return TERM_MIN;
                    1: return TERM_MAX;
                    2: return '0;
                    3: return '1;
                    default: return TERM_W'(1);
                endcase
            end
            FLAVOUR_SMALL: return TERM_W'(small_value);
            FLAVOUR_SPARSE: begin
                if (is_coeff || $urandom_range(0, 2) != 0) begin
                    return '0;
                end
                return TERM_W'(small_value);
            end
            default: return $urandom;
        endcase
    endfunction

    // Write the order register; only called while the block is idle.
    task automatic set_order(input logic [ORDER_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_order <= value;
        do @(posedge clk); while (!cfg_ready);
        gf_order = value;
        orders_written++;
        cfg_valid <= 1'b0;
    endtask

    // Offer one item, possibly after a short gap, and record its prediction.
    task automatic send_item(input logic [TERM_W-1:0] term,
                             input logic [TERM_W-1:0] coeff);
        if (idling && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_term  <= term;
        in_coeff <= coeff;
        do @(posedge clk); while (!in_ready);
        pending_coeffs.push_back(predict_coeff(term, coeff));
        items_sent++;
    endtask

    // Stop offering items until every predicted result has arrived.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_coeffs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Output side: random stalls, and a long hold-off when one is requested.
    initial begin : result_receiver
        int held;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_request > 0) begin
                held         = hold_request;
                hold_request = 0;
                out_ready <= 1'b0;
                repeat (held) @(posedge clk);
            end else if (idling && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each accepted result item with the oldest prediction.
    always @(posedge clk) begin : result_check
        t_gf_coeff want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_coeffs.size() == 0) begin
                $error("unexpected result item, coeff_index %0d", out_index);
                mismatch_count++;
            end else begin
                want = pending_coeffs.pop_front();
                coeffs_checked++;
                if (out_numer !== want.numer) begin
                    $error("numerator_coeff: expected %0d, actual %0d",
                           $signed(want.numer), $signed(out_numer));
                    mismatch_count++;
                end
                if (out_denom !== want.denom) begin
                    $error("denominator_coeff: expected %0d, actual %0d",
                           $signed(want.denom), $signed(out_denom));
                    mismatch_count++;
                end
                if (out_index !== want.index) begin
                    $error("coeff_index: expected %0d, actual %0d", want.index, out_index);
                    mismatch_count++;
                end
                if (out_last !== want.last) begin
                    $error("is_last: expected %0d, actual %0d", want.last, out_last);
                    mismatch_count++;
                end
                if (out_degree !== want.degree) begin
                    $error("numerator_degree: expected %0d, actual %0d",
                           want.degree, out_degree);
                    mismatch_count++;
                end
                if (out_all_zero !== want.all_zero) begin
                    $error("numerator_all_zero: expected %0d, actual %0d",
                           want.all_zero, out_all_zero);
                    mismatch_count++;
                end
            end
        end
    end

    // Order left at its reset value: every item is a job of its own.
    task automatic test_default_order();
        send_item(TERM_MAX, TERM_MIN);
        send_item(TERM_MIN, TERM_MAX);
        send_item('0, '0);
        send_item('1, '1);
        wait_for_results();
    endtask

    // Order zero behaves as order one.
    task automatic test_order_zero();
        set_order('0);
        send_item(TERM_W'(1), TERM_MAX);
        send_item(32'h5555_5555, 32'haaaa_aaaa);
        wait_for_results();
    endtask

    // Extreme terms and coefficients make the convolution wrap.
    task automatic test_wrapping_job();
        set_order(ORDER_W'(4));
        repeat (4) send_item(TERM_MIN, TERM_MIN);
        wait_for_results();
    endtask

    // Jobs with an all-zero numerator, and with zeros above the degree.
    task automatic test_zero_numerator();
        set_order(ORDER_W'(3));
        repeat (3) send_item('0, $urandom);
        send_item(TERM_W'(7), '0);
        send_item('0, '0);
        send_item('0, '0);
        send_item('0, TERM_W'(3));
        send_item('0, '0);
        send_item(TERM_W'(9), '0);
        wait_for_results();
    endtask

    // Lowering the order part way through a job ends it at the next item.
    task automatic test_order_change_mid_job();
        set_order(ORDER_W'(6));
        repeat (3) send_item($urandom, $urandom);
        wait_for_results();
        set_order(ORDER_W'(2));
        repeat (3) send_item($urandom, $urandom);
        wait_for_results();
    endtask

    // The largest order value saturates to the deepest job.
    task automatic test_saturated_order();
        t_value_flavour flavour;
        set_order(ORDER_TOP);
        repeat (MAX_ORDER) begin
            flavour = ($urandom_range(0, 1) == 0) ? FLAVOUR_WIDE : FLAVOUR_EDGES;
            send_item(draw_value(flavour, 1'b0), draw_value(flavour, 1'b1));
        end
        wait_for_results();
    endtask

    // The output is held off long enough for the block to stall its input.
    task automatic test_output_backpressure();
        set_order(ORDER_W'(4));
        hold_request = LONG_HOLD;
        repeat (16) send_item($urandom, $urandom);
        wait_for_results();
    endtask

    // Random orders and contents; some phases stop part way through a job.
    task automatic test_random_jobs();
        int                 roll;
        int                 span;
        int                 count;
        int                 n;
        logic [ORDER_W-1:0] ord;
        t_value_flavour     flavour;
        flavour = FLAVOUR_WIDE;
        while (items_sent < RANDOM_TARGET) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                ord = ORDER_W'($urandom_range(1, 8));
            end else if (roll < 75) begin
                ord = ORDER_W'($urandom_range(9, 24));
            end else if (roll < 85) begin
                ord = ORDER_W'($urandom_range(25, MAX_ORDER));
            end else if (roll < 93) begin
                ord = '0;
            end else begin
                ord = ORDER_W'($urandom_range(MAX_ORDER + 1, 127));
            end
            span = (ord == 0) ? 1 : ((ord > MAX_ORDER) ? MAX_ORDER : int'(ord));
            // Small orders run several jobs, middle ones one or two, large ones a single job.
            if (span <= 8) begin
                count = span * $urandom_range(2, 6);
            end else if (span <= 24) begin
                count = span * $urandom_range(1, 2);
            end else begin
                count = span;
            end
            if ($urandom_range(0, 4) == 0) begin
                count -= $urandom_range(0, span - 1);
            end
            idling = ($urandom_range(0, 3) != 0);
            set_order(ord);
            for (n = 0; n < count; n++) begin
                if (n % span == 0) begin
                    flavour = t_value_flavour'($urandom_range(0, 3));
                end
                send_item(draw_value(flavour, 1'b0), draw_value(flavour, 1'b1));
            end
            wait_for_results();
        end
    endtask

    // Final stretch at full rate on both sides.
    task automatic test_steady_tail();
        t_value_flavour flavour;
        idling = 1'b0;
        set_order(ORDER_W'($urandom_range(1, 8)));
        repeat (TAIL_ITEMS) begin
            flavour = t_value_flavour'($urandom_range(0, 3));
            send_item(draw_value(flavour, 1'b0), draw_value(flavour, 1'b1));
        end
        wait_for_results();
    endtask

    // Reset once, run each test in turn, then report.
    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_order();
        test_order_zero();
        test_wrapping_job();
        test_zero_numerator();
        test_order_change_mid_job();
        test_saturated_order();
        test_output_backpressure();
        test_random_jobs();
        test_steady_tail();
        if (pending_coeffs.size() != 0) begin
            $error("%0d predicted results never arrived", pending_coeffs.size());
            mismatch_count++;
        end
        $display("Run covered %0d items in %0d jobs over %0d order writes, %0d cycles.",
                 items_sent, jobs_done, orders_written, cycle_count);
        $display("Checked %0d result items, %0d field mismatches.",
                 coeffs_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
